// ----- sv/dlps_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, register codes and the Hann window table of the pitch shifter.
package dlps_pkg;

	// Fraction bits of the head delays; the pitch register uses the same fraction.
	localparam int FRAC_W = 16;
	localparam int SAMPLE_W = 12;
	localparam int MIDPOINT = 2048;

	// Crossfade length in samples, and the width of the fade counter.
	localparam int FADE_LEN = 1024;
	localparam int FC_W = $clog2(FADE_LEN);
	localparam int WIN_W = 16;

	// Configuration register indexes and widths.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 18;
	localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WET    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 2'd2;

	localparam int PITCH_W = 18;
	localparam int WET_W = 9;
	localparam logic [PITCH_W-1:0] PITCH_ONE   = 18'd65536;
	localparam logic [PITCH_W-1:0] PITCH_RESET = 18'd66519;
	localparam logic [WET_W-1:0]   WET_FULL    = 9'd256;
	localparam logic [WET_W-1:0]   WET_RESET   = 9'd128;

	// The window is symmetric, so only the first half is stored, indexed by the
	// distance from the nearer end of the full 2*FADE_LEN window.
	localparam longint unsigned WIN_M = longint'(2 * FADE_LEN - 1);
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	typedef logic [WIN_W-1:0] win_tab_t [FADE_LEN];

	// sin^2 of the window angle, from a seven-term Taylor series in Q30, in Q1.15.
	function automatic logic [WIN_W-1:0] hann_entry(input int unsigned nr);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint s;
		longint unsigned sq;
		x = (longint'(nr) * PI_Q30) / WIN_M;
		x2 = (x * x) >> 30;
		term = x;
		s = longint'(x);
		term = ((term * x2) >> 30) / 6;
		s = s - longint'(term);
		term = ((term * x2) >> 30) / 20;
		s = s + longint'(term);
		term = ((term * x2) >> 30) / 42;
		s = s - longint'(term);
		term = ((term * x2) >> 30) / 72;
		s = s + longint'(term);
		term = ((term * x2) >> 30) / 110;
		s = s - longint'(term);
		term = ((term * x2) >> 30) / 156;
		s = s + longint'(term);
		if (s < 0) begin
			s = 0;
		end
		if (s > (longint'(1) << 30)) begin
			s = longint'(1) << 30;
		end
		sq = (longint'(s) * longint'(s) + (longint'(1) << 44)) >> 45;
		return sq[WIN_W-1:0];
	endfunction

	function automatic win_tab_t build_win_tab();
		win_tab_t t;
		for (int n = 0; n < FADE_LEN; n++) begin
			t[n] = hann_entry(n);
		end
		return t;
	endfunction

	localparam win_tab_t WIN_TAB = build_win_tab();

endpackage

// ----- sv/delay_line_pitch_shifter.sv -----
`timescale 1ns / 1ps
// Dual-head delay-line pitch shifter: delay memory, read heads, crossfade and mix.

// Each input beat carries one unsigned 12-bit sample (midpoint 2048) and yields
// exactly one output beat. The sample is centred and written into a circular
// delay memory of LINE_DEPTH entries; two read heads trail the write position by
// fractional delays (16 fraction bits) and are read with linear interpolation.
// One head is heard at a time; when the silent head's delay reaches zero a
// Hann-window crossfade of 1024 samples moves to it. Both delays shrink by
// (pitch - 1) per sample, not at all below unity pitch, and wrap by MAX_DELAY.
// The wet signal is mixed with the dry input by wet_level, recentred and
// saturated to 0 .. 4095; bypass passes the input unchanged while all state
// still advances. An item passes through the accept state, the tap read states
// ST_RDA and ST_RDB (one per head, through both read ports of the memory) and
// the interpolation, crossfade, mix and output states; no new beat is taken
// until the item is through. A finished result waits in the output register
// while the next beat is accepted. The delay memory is not cleared after reset:
// the write position sweeps it in order, so an entry above the write position
// reads as zero until the write position has wrapped once. Configuration writes
// are taken in any cycle and must only be issued while no beat is in flight.
module delay_line_pitch_shifter #(
	parameter int MAX_DELAY = 2048,
	parameter int LINE_DEPTH = 2052
) (
	input  logic clk,
	input  logic arst_n,

	// Configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dlps_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dlps_pkg::CFG_DATA_W-1:0]     cfg_data,

	// Input samples
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,    // [11:0] sample_in, [15:12] zero

	// Output samples
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata     // [11:0] sample_out, [15:12] zero
);

	localparam int FW = dlps_pkg::FRAC_W;
	localparam int AW = $clog2(LINE_DEPTH);
	// Delay width: holds MAX_DELAY itself in Q.FW.
	localparam int DW = $clog2(MAX_DELAY + 1) + FW;
	// Signed read position before wrapping into the memory.
	localparam int PW = AW + FW + 1;
	localparam logic [DW-1:0] SPAN_D = DW'(longint'(MAX_DELAY) << FW);
	localparam logic [DW-1:0] HALF_D = DW'((longint'(MAX_DELAY) << FW) >> 1);
	localparam logic signed [PW-1:0] SPAN_L = PW'(longint'(LINE_DEPTH) << FW);
	localparam logic [AW-1:0] LAST_ADDR = AW'(LINE_DEPTH - 1);
	localparam int FCW = dlps_pkg::FC_W;

	// Sequencer states
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RDA  = 4'd1;
	localparam logic [3:0] ST_RDB  = 4'd2;
	localparam logic [3:0] ST_INT  = 4'd3;
	localparam logic [3:0] ST_SB   = 4'd4;
	localparam logic [3:0] ST_FADE = 4'd5;
	localparam logic [3:0] ST_WET  = 4'd6;
	localparam logic [3:0] ST_MIX  = 4'd7;
	localparam logic [3:0] ST_OUT  = 4'd8;

	// Interpolation: (a*(1-f) + b*f) / 2^16 truncated toward zero, written as
	// a*2^16 + (b-a)*f so that only one product is needed per head.
	function automatic logic signed [11:0] interp_fin(input logic signed [11:0] base,
			input logic signed [29:0] prod);
		logic signed [29:0] n;
		logic signed [13:0] q;
		n = {{2{base[11]}}, base, 16'b0} + prod;
		q = n[29:16];
		if (n[29] && (n[15:0] != 16'd0)) begin
			q = q + 14'sd1;
		end
		return q[11:0];
	endfunction

	// Control state
	logic [3:0]                         state_q;
	logic [AW-1:0]                      wp_q;
	logic                               full_q;
	logic [DW-1:0]                      head_a_q;
	logic [DW-1:0]                      head_b_q;
	logic [FCW-1:0]                     fc_q;
	logic                               act_q;
	logic [dlps_pkg::PITCH_W-1:0]       pitch_q;
	logic [dlps_pkg::WET_W-1:0]         wet_lvl_q;
	logic                               bypass_q;
	logic                               out_valid_q;

	// Datapath registers
	logic [11:0]                        out_q;
	logic [11:0]                        x_q;
	logic signed [11:0]                 line_mem [LINE_DEPTH];
	logic signed [11:0]                 rd0_q;
	logic signed [11:0]                 rd1_q;
	logic                               v0_q;
	logic                               v1_q;
	logic [FW-1:0]                      fr_q;
	logic [dlps_pkg::WIN_W-1:0]         win_rd_q;
	logic [dlps_pkg::WIN_W-1:0]         wi_q;
	logic signed [11:0]                 base_q;
	logic signed [29:0]                 prod_q;
	logic signed [11:0]                 sa_q;
	logic signed [11:0]                 sb_q;
	logic signed [28:0]                 p1_q;
	logic signed [28:0]                 p2_q;
	logic signed [13:0]                 wet_q;
	logic signed [23:0]                 m1_q;
	logic signed [21:0]                 m2_q;

	// Read head address unit, shared by both heads
	logic [DW-1:0]                      head_sel;
	logic signed [PW-1:0]               pos_raw;
	logic signed [PW-1:0]               pos;
	logic [AW-1:0]                      ia;
	logic [AW-1:0]                      ib;
	logic [FW-1:0]                      frac;
	logic [FCW-1:0]                     win_addr;

	// Arithmetic
	logic signed [11:0]                 tap_a;
	logic signed [11:0]                 tap_b;
	logic signed [12:0]                 diff;
	logic signed [11:0]                 s_in;
	logic signed [11:0]                 s_out;
	logic signed [29:0]                 fade_sum;
	logic signed [14:0]                 fade_q;
	logic [dlps_pkg::WET_W-1:0]         wl;
	logic [dlps_pkg::WET_W-1:0]         dl;
	logic signed [24:0]                 mix_sum;
	logic signed [16:0]                 mix_q;
	logic signed [17:0]                 res;
	logic [11:0]                        res_sat;

	// State update
	logic [dlps_pkg::PITCH_W-1:0]       delta;
	logic [FCW:0]                       fc_inc;
	logic [FCW-1:0]                     fc_n;
	logic                               act_n;
	logic signed [DW:0]                 da;
	logic signed [DW:0]                 db;
	logic [DW-1:0]                      head_a_n;
	logic [DW-1:0]                      head_b_n;

	logic in_fire;
	logic out_done;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_q};
	assign out_done      = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

	// Read position of the head being addressed: write position minus delay,
	// wrapped once into the memory. The taps of a head are the entry at the
	// integer part and the one after it.
	always_comb begin
		head_sel = (state_q == ST_RDA) ? head_a_q : head_b_q;
		pos_raw  = $signed({1'b0, wp_q, {FW{1'b0}}}) - $signed({{(PW - DW){1'b0}}, head_sel});
		pos      = pos_raw[PW-1] ? (pos_raw + SPAN_L) : pos_raw;
		ia       = pos[AW+FW-1:FW];
		frac     = pos[FW-1:0];
		ib       = (ia == LAST_ADDR) ? '0 : (ia + AW'(1));
		win_addr = (state_q == ST_RDA) ? fc_q : (FCW'(dlps_pkg::FADE_LEN - 1) - fc_q);
	end

	// Delay memory: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			line_mem[wp_q] <= {~s_axis_tdata[11], s_axis_tdata[10:0]};
		end
		rd0_q <= line_mem[ia];
		rd1_q <= line_mem[ib];
	end

	// Window table, read in the memory read states ST_RDA and ST_RDB only.
	always_ff @(posedge clk) begin
		if ((state_q == ST_RDA) || (state_q == ST_RDB)) begin
			win_rd_q <= dlps_pkg::WIN_TAB[win_addr];
		end
	end

	// Arithmetic on the registered taps and products.
	always_comb begin
		tap_a = v0_q ? rd0_q : 12'sd0;
		tap_b = v1_q ? rd1_q : 12'sd0;
		diff  = {tap_b[11], tap_b} - {tap_a[11], tap_a};
		// The incoming head is the one not yet heard.
		s_in  = act_q ? sa_q : sb_q;
		s_out = act_q ? sb_q : sa_q;
		fade_sum = {p1_q[28], p1_q} + {p2_q[28], p2_q};
		fade_q   = fade_sum[29:15];
		if (fade_sum[29] && (fade_sum[14:0] != 15'd0)) begin
			fade_q = fade_q + 15'sd1;
		end
		wl = (wet_lvl_q > dlps_pkg::WET_FULL) ? dlps_pkg::WET_FULL : wet_lvl_q;
		dl = dlps_pkg::WET_FULL - wl;
		mix_sum = {m1_q[23], m1_q} + {{3{m2_q[21]}}, m2_q};
		mix_q   = mix_sum[24:8];
		if (mix_sum[24] && (mix_sum[7:0] != 8'd0)) begin
			mix_q = mix_q + 17'sd1;
		end
		res = {mix_q[16], mix_q} + 18'sd2048;
		if (res[17]) begin
			res_sat = 12'd0;
		end else if (res > 18'sd4095) begin
			res_sat = 12'd4095;
		end else begin
			res_sat = res[11:0];
		end
	end

	// Datapath sequencing; the stage that each register serves is the state
	// in which it is loaded.
	always_ff @(posedge clk) begin
		fr_q <= frac;
		v0_q <= full_q || (ia <= wp_q);
		v1_q <= full_q || (ib <= wp_q);
		if (in_fire) begin
			x_q <= s_axis_tdata[11:0];
		end
		unique case (state_q)
			ST_RDB: begin
				wi_q   <= win_rd_q;
				base_q <= tap_a;
				prod_q <= diff * $signed({1'b0, fr_q});
			end
			ST_INT: begin
				sa_q   <= interp_fin(base_q, prod_q);
				base_q <= tap_a;
				prod_q <= diff * $signed({1'b0, fr_q});
			end
			ST_SB: begin
				sb_q <= interp_fin(base_q, prod_q);
			end
			ST_FADE: begin
				p1_q <= $signed({1'b0, wi_q}) * s_in;
				p2_q <= $signed({1'b0, win_rd_q}) * s_out;
			end
			ST_WET: begin
				if (fc_q != '0) begin
					wet_q <= fade_q[13:0];
				end else begin
					wet_q <= {{2{s_out[11]}}, s_out};
				end
			end
			ST_MIX: begin
				m1_q <= $signed({1'b0, wl}) * wet_q;
				m2_q <= $signed({1'b0, dl}) * $signed({~x_q[11], x_q[10:0]});
			end
			ST_OUT: begin
				if (out_done) begin
					out_q <= bypass_q ? x_q : res_sat;
				end
			end
			default: begin
			end
		endcase
	end

	// Head and crossfade update at the end of an item.
	always_comb begin
		delta  = (pitch_q < dlps_pkg::PITCH_ONE) ? '0 : (pitch_q - dlps_pkg::PITCH_ONE);
		fc_inc = {1'b0, fc_q} + (FCW + 1)'(1);
		fc_n   = fc_q;
		act_n  = act_q;
		if (fc_q != '0) begin
			if (fc_inc == (FCW + 1)'(dlps_pkg::FADE_LEN)) begin
				fc_n  = '0;
				act_n = ~act_q;
			end else begin
				fc_n = fc_inc[FCW-1:0];
			end
		end
		da = $signed({1'b0, head_a_q}) - $signed({{(DW + 1 - dlps_pkg::PITCH_W){1'b0}}, delta});
		db = $signed({1'b0, head_b_q}) - $signed({{(DW + 1 - dlps_pkg::PITCH_W){1'b0}}, delta});
		if (delta != '0) begin
			// The silent head reaching zero starts a crossfade towards it.
			if ((da <= 0) && act_n && (fc_n == '0)) begin
				fc_n = FCW'(1);
				da   = '0;
			end else if ((db <= 0) && !act_n && (fc_n == '0)) begin
				fc_n = FCW'(1);
				db   = '0;
			end
			if (da[DW]) begin
				da = da + $signed({1'b0, SPAN_D});
			end
			if (db[DW]) begin
				db = db + $signed({1'b0, SPAN_D});
			end
		end
		head_a_n = da[DW-1:0];
		head_b_n = db[DW-1:0];
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			full_q      <= 1'b0;
			head_a_q    <= SPAN_D;
			head_b_q    <= HALF_D;
			fc_q        <= '0;
			act_q       <= 1'b0;
			pitch_q     <= dlps_pkg::PITCH_RESET;
			wet_lvl_q   <= dlps_pkg::WET_RESET;
			bypass_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					dlps_pkg::CFG_PITCH:  pitch_q   <= cfg_data;
					dlps_pkg::CFG_WET:    wet_lvl_q <= cfg_data[dlps_pkg::WET_W-1:0];
					dlps_pkg::CFG_BYPASS: bypass_q  <= cfg_data[0];
					default: begin
					end
				endcase
			end

			if (out_done) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_RDA;
					end
				end
				ST_RDA:  state_q <= ST_RDB;
				ST_RDB:  state_q <= ST_INT;
				ST_INT:  state_q <= ST_SB;
				ST_SB:   state_q <= ST_FADE;
				ST_FADE: state_q <= ST_WET;
				ST_WET:  state_q <= ST_MIX;
				ST_MIX:  state_q <= ST_OUT;
				ST_OUT: begin
					if (out_done) begin
						state_q  <= ST_IDLE;
						head_a_q <= head_a_n;
						head_b_q <= head_b_n;
						fc_q     <= fc_n;
						act_q    <= act_n;
						if (wp_q == LAST_ADDR) begin
							wp_q   <= '0;
							full_q <= 1'b1;
						end else begin
							wp_q <= wp_q + AW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the dual-head delay-line pitch shifter.
module tb;

	// Geometry of the block under test, passed down so that the model matches it.
	localparam int MAX_DELAY  = 2048;
	localparam int LINE_DEPTH = 2052;
	localparam int FADE_LEN   = dlps_pkg::FADE_LEN;
	localparam int FRAC_W     = dlps_pkg::FRAC_W;
	localparam int MIDPOINT   = dlps_pkg::MIDPOINT;

	// Register index that no register answers to; a write to it must change nothing.
	localparam logic [dlps_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// Q30 value of pi, used to build the crossfade window.
	localparam longint unsigned PI_Q30 = 64'd3373259426;
	localparam longint ONE_Q = longint'(1) << FRAC_W;

	// Cycles the block needs for one sample, used for the quiet period at the end.
	localparam int SAMPLE_CYCLES = 9;
	localparam int HOLD_CYCLES = 1500;
	localparam int PHASE_ITEMS = 250;
	localparam int MAX_PRINTS = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [dlps_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
	logic [dlps_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;    // [11:0] sample_in, [15:12] zero

	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [11:0] sample_out, [15:12] zero

	delay_line_pitch_shifter #(
		.MAX_DELAY(MAX_DELAY),
		.LINE_DEPTH(LINE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Shadow of the block: its own delay line, heads, fade and registers.
	// ------------------------------------------------------------------
	logic signed [11:0] line_mem [LINE_DEPTH];
	longint hann_win [2 * FADE_LEN];
	int unsigned wr_pos;
	longint dly_a;
	longint dly_b;
	int unsigned fade_pos;
	bit hear_b;
	logic [dlps_pkg::PITCH_W-1:0] pitch_q;
	logic [dlps_pkg::WET_W-1:0] wet_q;
	bit bypass_q;

	// Output samples still owed by the block, oldest first.
	logic [11:0] shifted_due [$];

	// Pacing of the two sides, as percentages of cycles.
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	// Free-running cycle count, and the cycle up to which the receiver refuses
	// every beat.
	int unsigned cycle_cnt = 0;
	int unsigned hold_end = 0;

	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned reg_writes = 0;
	int unsigned fades_started = 0;
	int unsigned bypass_items = 0;

	// Window weight n of 0 .. 2*FADE_LEN-1 in Q1.15: sin^2 of the angle, with the
	// sine taken from a seven-term Taylor series in Q30 and the window folded
	// about its centre.
	function automatic longint hann_q15(int unsigned n);
		longint unsigned span_m;
		longint unsigned fold_n;
		longint unsigned ang;
		longint unsigned ang2;
		longint unsigned term;
		longint acc;
		int k;
		span_m = 2 * FADE_LEN - 1;
		fold_n = (2 * longint'(n) <= span_m) ? n : span_m - n;
		ang = (fold_n * PI_Q30) / span_m;
		ang2 = (ang * ang) >> 30;
		term = ang;
		acc = longint'(ang);
		for (k = 1; k <= 6; k++) begin
			term = ((term * ang2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - longint'(term);
			end else begin
				acc = acc + longint'(term);
			end
		end
		if (acc < 0) begin
			acc = 0;
		end
		if (acc > (longint'(1) << 30)) begin
			acc = longint'(1) << 30;
		end
		return (acc * acc + (longint'(1) << 44)) >>> 45;
	endfunction

	task automatic reset_shadow();
		for (int n = 0; n < 2 * FADE_LEN; n++) begin
			hann_win[n] = hann_q15(n);
		end
		for (int n = 0; n < LINE_DEPTH; n++) begin
			line_mem[n] = '0;
		end
		wr_pos = 0;
		dly_a = longint'(MAX_DELAY) * ONE_Q;
		dly_b = (longint'(MAX_DELAY) * ONE_Q) >>> 1;
		fade_pos = 0;
		hear_b = 1'b0;
		pitch_q = dlps_pkg::PITCH_RESET;
		wet_q = dlps_pkg::WET_RESET;
		bypass_q = 1'b0;
	endtask

	// Linear interpolation between the two line entries around a fractional delay
	// behind the write position, truncated toward zero.
	function automatic longint tap_read(longint dly);
		longint line_span;
		longint pos;
		longint frac;
		longint lo;
		longint hi;
		int unsigned ia;
		int unsigned ib;
		line_span = longint'(LINE_DEPTH) * ONE_Q;
		pos = longint'(wr_pos) * ONE_Q - dly;
		while (pos < 0) begin
			pos = pos + line_span;
		end
		while (pos >= line_span) begin
			pos = pos - line_span;
		end
		ia = 32'(pos >>> FRAC_W);
		frac = pos & (ONE_Q - 1);
		ib = (ia + 1 >= LINE_DEPTH) ? 0 : ia + 1;
		lo = line_mem[ia];
		hi = line_mem[ib];
		return (lo * (ONE_Q - frac) + hi * frac) / ONE_Q;
	endfunction

	// Advances the shadow by one input sample and returns the output sample due.
	function automatic logic [11:0] pitch_shift_step(logic [11:0] x);
		longint dry;
		longint sa;
		longint sb;
		longint wet;
		longint wi;
		longint wo;
		longint mix;
		longint res;
		longint step;
		longint wrap;
		longint p;
		longint wl;
		dry = longint'(x) - MIDPOINT;
		p = (pitch_q < dlps_pkg::PITCH_ONE) ? dlps_pkg::PITCH_ONE : pitch_q;
		wl = (wet_q > dlps_pkg::WET_FULL) ? 256 : longint'(wet_q);
		wrap = longint'(MAX_DELAY) * ONE_Q;

		line_mem[wr_pos] = dry[11:0];
		sa = tap_read(dly_a);
		sb = tap_read(dly_b);

		// During a fade the incoming head rises with the window while the
		// outgoing one falls with the second half of it.
		if (fade_pos != 0) begin
			wi = hann_win[fade_pos];
			wo = hann_win[fade_pos + FADE_LEN];
			if (hear_b) begin
				wet = (wi * sa + wo * sb) / 32768;
			end else begin
				wet = (wi * sb + wo * sa) / 32768;
			end
			fade_pos++;
			if (fade_pos >= FADE_LEN) begin
				fade_pos = 0;
				hear_b = !hear_b;
			end
		end else begin
			wet = hear_b ? sb : sa;
		end

		// Both heads close in by (pitch - 1) each sample. The silent head reaching
		// zero starts a fade unless one is already running, in which case it wraps.
		step = p - ONE_Q;
		dly_a = dly_a - step;
		dly_b = dly_b - step;
		if (step > 0) begin
			if (dly_a <= 0 && hear_b && fade_pos == 0) begin
				fade_pos = 1;
				dly_a = 0;
				fades_started++;
			end else if (dly_b <= 0 && !hear_b && fade_pos == 0) begin
				fade_pos = 1;
				dly_b = 0;
				fades_started++;
			end
			while (dly_a < 0) begin
				dly_a = dly_a + wrap;
			end
			while (dly_b < 0) begin
				dly_b = dly_b + wrap;
			end
		end

		mix = (wl * wet + (256 - wl) * dry) / 256;
		res = mix + MIDPOINT;
		if (res < 0) begin
			res = 0;
		end
		if (res > 4095) begin
			res = 4095;
		end

		wr_pos = (wr_pos + 1 >= LINE_DEPTH) ? 0 : wr_pos + 1;
		return bypass_q ? x : res[11:0];
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string what, int got, int want);
		if (mismatches < MAX_PRINTS) begin
			$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
		end
		mismatches++;
	endtask

	// Cycles are counted here; the long hold-off of the receiver is measured
	// against this count.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
	end

	// The receiver: every accepted beat is compared with the oldest sample owed,
	// and tready is drawn afresh for the next edge.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (shifted_due.size() == 0) begin
				flag_mismatch("output beat with nothing outstanding", m_axis_tdata[11:0], -1);
			end else if (m_axis_tdata[11:0] !== shifted_due[0]) begin
				flag_mismatch("sample_out", m_axis_tdata[11:0], shifted_due.pop_front());
			end else begin
				void'(shifted_due.pop_front());
			end
		end
		if (cycle_cnt < hold_end) begin
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Driving. All tasks start and end just after a rising edge.
	// ------------------------------------------------------------------

	// Offers one sample, after a random gap, and records the output it must give.
	// tvalid is left high so that back-to-back beats need no extra edge.
	task automatic send_sample(logic [11:0] x);
		if (cfg_valid) begin
			cfg_valid <= 1'b0;
		end
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'b0000, x};
		do @(posedge clk); while (!s_axis_tready);
		shifted_due.push_back(pitch_shift_step(x));
		items_sent++;
		if (bypass_q) begin
			bypass_items++;
		end
	endtask

	// Stops offering samples and waits until every owed sample has come out.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (shifted_due.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// One register write; only ever issued with the block drained. cfg_valid
	// stays high for a following write and is lowered by the next sample.
	task automatic write_reg(logic [dlps_pkg::CFG_IDX_W-1:0] idx,
			logic [dlps_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
		case (idx)
			dlps_pkg::CFG_PITCH: begin
				pitch_q = val[dlps_pkg::PITCH_W-1:0];
			end
			dlps_pkg::CFG_WET: begin
				wet_q = val[dlps_pkg::WET_W-1:0];
			end
			dlps_pkg::CFG_BYPASS: begin
				bypass_q = val[0];
			end
			default: begin
			end
		endcase
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Settings straight out of reset, with full-scale, midpoint and
	// alternating-bit samples.
	task automatic test_reset_defaults();
		send_sample(12'h000);
		send_sample(12'hFFF);
		send_sample(12'h800);
		send_sample(12'hAAA);
		send_sample(12'h555);
		wait_drained();
	endtask

	// Every register at its extremes and beyond: dry-only and wet-only mixes, a
	// wet level past full scale, bypass, pitch below unity, at unity, at two and
	// at the top of the field, and a write to the unused index.
	task automatic test_register_extremes();
		write_reg(dlps_pkg::CFG_WET, '0);
		send_sample(12'hFFF);
		send_sample(12'h000);
		wait_drained();
		write_reg(dlps_pkg::CFG_WET, 18'(dlps_pkg::WET_FULL));
		send_sample(12'h123);
		send_sample(12'hEDC);
		wait_drained();
		write_reg(dlps_pkg::CFG_WET, 18'h001FF);
		send_sample(12'h000);
		send_sample(12'hFFF);
		wait_drained();
		write_reg(dlps_pkg::CFG_BYPASS, 18'h00001);
		send_sample(12'h000);
		send_sample(12'hFFF);
		wait_drained();
		write_reg(dlps_pkg::CFG_BYPASS, '0);
		write_reg(dlps_pkg::CFG_PITCH, '0);
		send_sample(12'h7FF);
		send_sample(12'h801);
		wait_drained();
		write_reg(dlps_pkg::CFG_PITCH, 18'(dlps_pkg::PITCH_ONE));
		send_sample(12'h400);
		wait_drained();
		write_reg(dlps_pkg::CFG_PITCH, 18'd131072);
		send_sample(12'hC00);
		send_sample(12'h3FF);
		wait_drained();
		write_reg(dlps_pkg::CFG_PITCH, 18'h3FFFF);
		write_reg(CFG_SPARE, 18'h3FFFF);
		send_sample(12'hFFF);
		send_sample(12'h001);
		send_sample(12'hFFE);
		wait_drained();
	endtask

	// One phase of random traffic under fresh random settings. Pitches lean to
	// the fast end so that heads run out and crossfades, including heads
	// wrapping mid-fade, happen often. A non-zero hold makes the receiver refuse
	// every beat for that many cycles while samples keep being offered.
	task automatic run_random_phase(int unsigned n_items, int unsigned send_pct,
			int unsigned stall_pct, int unsigned hold);
		int unsigned r;
		logic [17:0] junk;
		logic [17:0] pitch;
		logic [8:0] wet;
		logic [11:0] x;
		send_idle_pct = send_pct;
		recv_stall_pct = stall_pct;

		r = $urandom_range(0, 99);
		if (r < 60) begin
			pitch = 18'($urandom_range(196608, 262143));
		end else if (r < 85) begin
			pitch = 18'($urandom_range(65536, 196607));
		end else begin
			pitch = 18'($urandom_range(0, 262143));
		end
		write_reg(dlps_pkg::CFG_PITCH, pitch);
		wet = ($urandom_range(0, 99) < 20) ? dlps_pkg::WET_FULL : 9'($urandom_range(0, 511));
		junk = 18'($urandom);
		// The bits above each register's width are don't-care and are filled at random.
		write_reg(dlps_pkg::CFG_WET, {junk[17:9], wet});
		junk = 18'($urandom);
		write_reg(dlps_pkg::CFG_BYPASS, {junk[17:1], ($urandom_range(0, 99) < 15) ? 1'b1 : 1'b0});

		if (hold != 0) begin
			hold_end = cycle_cnt + hold;
		end
		for (int i = 0; i < n_items; i++) begin
			r = $urandom_range(0, 99);
			if (r < 8) begin
				x = 12'h000;
			end else if (r < 16) begin
				x = 12'hFFF;
			end else begin
				x = 12'($urandom_range(0, 4095));
			end
			send_sample(x);
		end
		wait_drained();
	endtask

	// Random traffic under each pacing of the two sides.
	task automatic test_random_traffic();
		run_random_phase(PHASE_ITEMS, 0, 0, 0);
		run_random_phase(PHASE_ITEMS, 59, 0, 0);
		run_random_phase(PHASE_ITEMS, 0, 59, 0);
		run_random_phase(PHASE_ITEMS, 15, 15, 0);
		run_random_phase(PHASE_ITEMS, 59, 59, 0);
	endtask

	// The receiver holds off for a long stretch so the block fills and stalls its
	// input; afterwards the sender waits for a full drain before carrying on.
	task automatic test_backpressure();
		run_random_phase(PHASE_ITEMS, 0, 0, HOLD_CYCLES);
		run_random_phase(PHASE_ITEMS, 15, 15, HOLD_CYCLES / 3);
	endtask

	initial begin
		reset_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_traffic();
		test_backpressure();

		// A quiet period in which any stray output beat would still be caught.
		wait_drained();
		repeat (4 * SAMPLE_CYCLES) @(posedge clk);
		if (shifted_due.size() != 0) begin
			flag_mismatch("output samples never delivered", 0, shifted_due.size());
		end

		$display("Sent %0d samples (%0d in bypass), checked %0d outputs, %0d register writes.",
			items_sent, bypass_items, results_seen, reg_writes);
		$display("Crossfades started: %0d; mismatches: %0d.", fades_started, mismatches);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Backstop in case the block stops answering altogether.
	initial begin
		#3000000;
		$display("Timed out with %0d output samples outstanding.", shifted_due.size());
		$display("tb NOT OK");
		$finish;
	end

endmodule

// ----- files.f -----
sv/dlps_pkg.sv
sv/delay_line_pitch_shifter.sv
tb/tb.sv
